@@ design/cft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the CSV field tokenizer
// Holds the field limits, byte codes, result kinds and the entry type that
// travels from the front end through the queue to the result stage.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int FIELD_BYTES = 512;
  localparam int MAX_COLUMNS = 1024;

  localparam int COL_W = 10;
  localparam int LEN_W = $clog2(FIELD_BYTES);

  localparam int COL_CAP_INT = ((MAX_COLUMNS - 1) < 1023) ? (MAX_COLUMNS - 1) : 1023;
  localparam logic [COL_W-1:0] COL_CAP = COL_W'(COL_CAP_INT);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_BYTES - 1);

  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOL = 1'b1;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] column;
    logic [7:0]       content;
  } result_t;

  // All results of one request; second is meaningful only when two is set.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage
`default_nettype wire

@@ design/cft_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cft_front: byte classifier and field state
// Classifies each request against the quoting state and produces the one
// or two results it causes, if any, as a single queue entry.
// ----------------------------------------------------------------------------
module cft_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      separator,
  input  wire logic            cmd,
  input  wire logic [7:0]      data,
  input  wire logic            accept,
  output logic                 entry_valid,
  output cft_pkg::entry_t      entry
);
  import cft_pkg::*;

  logic             inside_quotes, inside_quotes_next;
  logic             quote_pending, quote_pending_next;
  logic             at_field_start, at_field_start_next;
  logic             dropping_rest, dropping_rest_next;
  logic [COL_W-1:0] column_number, column_number_next;
  logic [LEN_W-1:0] field_length, field_length_next;

  always_comb begin
    logic    do_unquoted;
    logic    u_emit;
    logic    has_any;
    result_t ures;

    inside_quotes_next  = inside_quotes;
    quote_pending_next  = quote_pending;
    at_field_start_next = at_field_start;
    dropping_rest_next  = dropping_rest;
    column_number_next  = column_number;
    field_length_next   = field_length;
    do_unquoted = 1'b0;
    u_emit      = 1'b0;
    has_any     = 1'b0;
    ures        = '0;
    entry       = '0;

    if (cmd == CMD_EOL) begin
      entry.first = '{kind: KIND_LINE, column: column_number_next, content: 8'd0};
      has_any = 1'b1;
      column_number_next  = '0;
      inside_quotes_next  = 1'b0;
      quote_pending_next  = 1'b0;
      at_field_start_next = 1'b1;
      dropping_rest_next  = 1'b0;
      field_length_next   = '0;
    end else if (inside_quotes_next) begin
      if (quote_pending_next) begin
        quote_pending_next = 1'b0;
        if (data == QUOTE_BYTE) begin
          // doubled quote: keep one
          if (field_length_next < LEN_MAX) begin
            entry.first = '{kind: KIND_BYTE, column: column_number_next, content: data};
            has_any = 1'b1;
            field_length_next = field_length_next + LEN_W'(1);
          end
        end else begin
          // closing quote: end the field, then reparse a non-separator byte
          entry.first = '{kind: KIND_FIELD, column: column_number_next, content: 8'd0};
          has_any = 1'b1;
          if (column_number_next < COL_CAP) begin
            column_number_next = column_number_next + COL_W'(1);
          end
          inside_quotes_next  = 1'b0;
          at_field_start_next = 1'b1;
          dropping_rest_next  = 1'b0;
          field_length_next   = '0;
          do_unquoted = (data != separator);
        end
      end else if (data == QUOTE_BYTE) begin
        quote_pending_next = 1'b1;
      end else if (field_length_next < LEN_MAX) begin
        entry.first = '{kind: KIND_BYTE, column: column_number_next, content: data};
        has_any = 1'b1;
        field_length_next = field_length_next + LEN_W'(1);
      end
    end else begin
      do_unquoted = 1'b1;
    end

    if (do_unquoted) begin
      if (at_field_start_next && data == QUOTE_BYTE) begin
        inside_quotes_next  = 1'b1;
        at_field_start_next = 1'b0;
      end else if (data == separator) begin
        ures = '{kind: KIND_FIELD, column: column_number_next, content: 8'd0};
        u_emit = 1'b1;
        if (column_number_next < COL_CAP) begin
          column_number_next = column_number_next + COL_W'(1);
        end
        inside_quotes_next  = 1'b0;
        quote_pending_next  = 1'b0;
        at_field_start_next = 1'b1;
        dropping_rest_next  = 1'b0;
        field_length_next   = '0;
      end else begin
        at_field_start_next = 1'b0;
        if (!dropping_rest_next) begin
          if (data == CR_BYTE || data == LF_BYTE) begin
            dropping_rest_next = 1'b1;
          end else if (field_length_next < LEN_MAX) begin
            ures = '{kind: KIND_BYTE, column: column_number_next, content: data};
            u_emit = 1'b1;
            field_length_next = field_length_next + LEN_W'(1);
          end
        end
      end
      if (u_emit) begin
        if (has_any) begin
          entry.second = ures;
          entry.two = 1'b1;
        end else begin
          entry.first = ures;
        end
        has_any = 1'b1;
      end
    end

    entry_valid = accept && has_any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes  <= 1'b0;
      quote_pending  <= 1'b0;
      at_field_start <= 1'b1;
      dropping_rest  <= 1'b0;
      column_number  <= '0;
      field_length   <= '0;
    end else if (accept) begin
      inside_quotes  <= inside_quotes_next;
      quote_pending  <= quote_pending_next;
      at_field_start <= at_field_start_next;
      dropping_rest  <= dropping_rest_next;
      column_number  <= column_number_next;
      field_length   <= field_length_next;
    end
  end

  a_col_cap: assert property (@(posedge clk) disable iff (rst)
    column_number <= COL_CAP)
    else $error("column number above cap");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    field_length <= LEN_MAX)
    else $error("field length above limit");

  a_pending_quoted: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> inside_quotes)
    else $error("quote pending outside a quoted field");

endmodule
`default_nettype wire

@@ design/cft_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cft_queue: entry queue between front end and result stage
// Small circular buffer of entries with occupancy count.
// ----------------------------------------------------------------------------
module cft_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire cft_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  output cft_pkg::entry_t      rd_data,
  output logic                 full,
  output logic                 nonempty
);
  import cft_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> nonempty)
    else $error("read from empty queue");

endmodule
`default_nettype wire

@@ design/cft_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cft_back: result stage
// Holds one entry and presents its results one per pop.
// ----------------------------------------------------------------------------
module cft_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cft_pkg::entry_t q_data,
  input  wire logic            q_nonempty,
  output logic                 q_rd,
  input  wire logic            pop,
  output logic                 empty,
  output logic [1:0]           kind,
  output logic [cft_pkg::COL_W-1:0] column,
  output logic [7:0]           content,
  output logic                 last_of_run
);
  import cft_pkg::*;

  entry_t  held;
  logic    valid;
  logic    sel;
  logic    load;
  result_t cur;

  assign empty       = !valid;
  assign last_of_run = !held.two || sel;
  assign cur         = sel ? held.second : held.first;
  assign kind        = cur.kind;
  assign column      = cur.column;
  assign content     = cur.content;

  // refill when nothing is held or the last result leaves
  assign load = !valid || (pop && last_of_run);
  assign q_rd = load && q_nonempty;

  always_ff @(posedge clk) begin
    if (load) begin
      held <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else if (load) begin
      valid <= q_nonempty;
      sel   <= 1'b0;
    end else if (pop) begin
      sel <= 1'b1;
    end
  end

  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    (valid && sel) |-> held.two)
    else $error("second result selected on single-result entry");

endmodule
`default_nettype wire

@@ design/csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming CSV field splitter
// Splits a line into fields at a programmable separator and unquotes
// quoted fields, tagging each kept byte with its column.
// ----------------------------------------------------------------------------
// Throughput: one request (a line byte or an end-of-line command) is taken
// every clock cycle while the four-entry result queue has room. Results
// leave at one per cycle while pop is held, so a request with two results (a
// closing quote followed by a byte that starts the next field) holds the
// output until both are popped; the queue absorbs these bursts. A result
// reaches the output ports through the queue and the result stage: the
// classifier writes the queue at the accepting edge, and the result stage
// loads an entry when it holds none or its last result is popped. Requests
// that keep nothing (an opening quote, a dropped byte) produce no result at
// all. last_of_run marks the final result of each request. The separator
// register takes writes at any time through cfg_valid/cfg_ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [7:0]  data,
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [cft_pkg::COL_W-1:0] column,
  output logic [7:0]       content,
  output logic             last_of_run
);
  import cft_pkg::*;

  logic [7:0] separator;
  logic       accept;
  logic       entry_valid;
  entry_t     entry;
  entry_t     q_data;
  logic       q_full;
  logic       q_nonempty;
  logic       q_rd;

  // Config register: always ready, single cycle write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEPARATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      separator <= cfg_data;
    end
  end

  // Hold off requests only when the queue has no room for another entry.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front end: classify the byte and update field state.
  cft_front u_front (
    .clk         (clk),
    .rst         (rst),
    .separator   (separator),
    .cmd         (cmd),
    .data        (data),
    .accept      (accept),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  // Decouple classification from result delivery.
  cft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_valid),
    .wr_data  (entry),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // Result stage: present entries one result at a time.
  cft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_nonempty  (q_nonempty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .column      (column),
    .content     (content),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

@@ test/csv_field_tokenizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_test: self-checking bench for the CSV field tokenizer
// Streams directed and random line bytes through the request queue, predicts
// every content, field-end and line-end token in step with each accepted
// request, and compares them in order against what the block pops out.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_test;
  import cft_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } req_t;

  typedef struct {
    logic [1:0]       tok_kind;
    logic [COL_W-1:0] tok_column;
    logic [7:0]       tok_content;
    logic             last_run;
  } token_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic [7:0]       cfg_data = 8'd0;
  logic             push = 1'b0;
  logic             cmd = CMD_BYTE;
  logic [7:0]       data = 8'd0;
  logic             pop = 1'b0;
  logic             cfg_ready;
  logic             full;
  logic             empty;
  logic [1:0]       kind;
  logic [COL_W-1:0] column;
  logic [7:0]       content;
  logic             last_of_run;

  csv_field_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .data        (data),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .column      (column),
    .content     (content),
    .last_of_run (last_of_run)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Requests waiting to be driven, and tokens waiting to be popped.
  req_t   pending_reqs[$];
  token_t expected_tokens[$];
  token_t run_tokens[$];
  token_t want;
  int     queued_items = 0;
  int     fail_count = 0;

  // Shadow copy of the tokenizer state and its separator register.
  logic [7:0]       exp_sep = SEPARATOR_RESET;
  logic             in_quotes = 1'b0;
  logic             quote_wait = 1'b0;
  logic             field_fresh = 1'b1;
  logic             skip_rest = 1'b0;
  logic [COL_W-1:0] col_now = '0;
  int               kept_len = 0;

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  task automatic emit(logic [1:0] k, logic [7:0] b);
    token_t t;
    t.tok_kind = k;
    t.tok_column = col_now;
    t.tok_content = b;
    t.last_run = 1'b0;
    run_tokens.push_back(t);
  endtask

  task automatic open_field();
    in_quotes = 1'b0;
    quote_wait = 1'b0;
    field_fresh = 1'b1;
    skip_rest = 1'b0;
    kept_len = 0;
  endtask

  // Emit the field-end token, then advance the column unless it is pinned.
  task automatic close_field();
    emit(KIND_FIELD, 8'd0);
    if (col_now < COL_CAP) col_now = col_now + 1'b1;
    open_field();
  endtask

  // Keep a content byte only while the field still has room.
  task automatic keep(logic [7:0] b);
    if (kept_len < FIELD_BYTES - 1) begin
      emit(KIND_BYTE, b);
      kept_len++;
    end
  endtask

  // Byte outside quotes: an opening quote only counts at field start, and the
  // separator is checked before CR/LF so a CR or LF separator still splits.
  task automatic plain(logic [7:0] b);
    if (field_fresh && b == QUOTE_BYTE) begin
      in_quotes = 1'b1;
      field_fresh = 1'b0;
    end else if (b == exp_sep) begin
      close_field();
    end else begin
      field_fresh = 1'b0;
      if (!skip_rest) begin
        if (b == CR_BYTE || b == LF_BYTE) skip_rest = 1'b1;
        else keep(b);
      end
    end
  endtask

  task automatic tokenize(logic c, logic [7:0] b);
    run_tokens.delete();
    if (c == CMD_EOL) begin
      emit(KIND_LINE, 8'd0);
      col_now = '0;
      open_field();
    end else if (in_quotes) begin
      if (quote_wait) begin
        // A quote is pending: the next byte decides how the field ends.
        quote_wait = 1'b0;
        if (b == QUOTE_BYTE) begin
          keep(b);
        end else if (b == exp_sep) begin
          close_field();
        end else begin
          close_field();
          plain(b);
        end
      end else if (b == QUOTE_BYTE) begin
        quote_wait = 1'b1;
      end else begin
        keep(b);
      end
    end else begin
      plain(b);
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_run = 1'b1;
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
  endtask

  // --------------------------------------------------------------------------
  // Random waits: flip into or out of a no-wait stretch now and then
  // --------------------------------------------------------------------------
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: change inputs at the falling edge
  // --------------------------------------------------------------------------
  logic req_taken = 1'b0;
  int   send_wait = 0;
  bit   send_calm = 1'b0;

  always @(posedge clk) begin
    req_taken <= 1'b0;
    if (!rst && push && !full) begin
      req_taken <= 1'b1;
      tokenize(cmd, data);
      void'(pending_reqs.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      // The last request went through (or none was up): draw the next wait.
      if (push) send_wait = draw_wait(send_calm);
      if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        push <= 1'b1;
        cmd <= pending_reqs[0].cmd;
        data <= pending_reqs[0].data;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: sample at the rising edge, stall pop at the falling edge
  // --------------------------------------------------------------------------
  logic tok_taken = 1'b0;
  int   recv_wait = 0;
  bit   recv_calm = 1'b0;

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", name, expected, actual);
    end
  endfunction

  always @(posedge clk) begin
    tok_taken <= 1'b0;
    if (!rst && pop && !empty) begin
      tok_taken <= 1'b1;
      if (expected_tokens.size() == 0) begin
        fail_count++;
        $error("unexpected result: kind %0d column %0d content %0d", kind, column, content);
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", want.tok_kind, kind);
        check_field("column", want.tok_column, column);
        check_field("content", want.tok_content, content);
        check_field("last_of_run", want.last_run, last_of_run);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (!pop || tok_taken) begin
      if (pop) recv_wait = draw_wait(recv_calm);
      if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b);
    req_t r;
    r.cmd = CMD_BYTE;
    r.data = b;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  // End of line; the data byte rides along and must be ignored.
  task automatic queue_eol(logic [7:0] junk);
    req_t r;
    r.cmd = CMD_EOL;
    r.data = junk;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // Unquoted content that neither splits, quotes nor truncates the field.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == exp_sep || b == QUOTE_BYTE || b == CR_BYTE || b == LF_BYTE)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] any_but_quote();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == QUOTE_BYTE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] line_break();
    return ($urandom_range(0, 1) == 0) ? CR_BYTE : LF_BYTE;
  endfunction

  // One well-formed line with random content: a mix of unquoted and quoted
  // fields, doubled quotes, stray CR/LF and bytes after a closing quote.
  task automatic queue_random_line();
    int nfields;
    int len;
    int r;
    nfields = $urandom_range(1, 6);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) queue_byte(exp_sep);
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
        queue_byte(QUOTE_BYTE);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            queue_byte(QUOTE_BYTE);
            queue_byte(QUOTE_BYTE);
          end else begin
            queue_byte(any_but_quote());
          end
        end
        queue_byte(QUOTE_BYTE);
        if ($urandom_range(0, 5) == 0) queue_byte(plain_byte());
      end else begin
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 15);
          if (i > 0 && r == 0) queue_byte(QUOTE_BYTE);
          else if (r == 1) queue_byte(line_break());
          else queue_byte(plain_byte());
        end
      end
    end
    queue_eol(8'($urandom_range(0, 255)));
  endtask

  // Noise: loose bytes biased toward the special codes, with stray line ends.
  task automatic queue_noise();
    int n;
    int r;
    n = $urandom_range(3, 12);
    repeat (n) begin
      r = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) queue_eol(8'($urandom_range(0, 255)));
      else if (r == 0) queue_byte(QUOTE_BYTE);
      else if (r == 1) queue_byte(exp_sep);
      else if (r == 2) queue_byte(line_break());
      else queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold off until every request is through and every token has come back,
  // then give requests that made no token time to leave the pipeline.
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || expected_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_separator(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    exp_sep = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [7:0] sep_plan[9];
  int         target;

  initial begin
    sep_plan = '{8'd44, 8'd0, 8'd255, QUOTE_BYTE, LF_BYTE, CR_BYTE, 8'd59, 8'd9, 8'd0};
    sep_plan[8] = 8'($urandom_range(0, 255));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines with the reset separator: doubled quote, a byte right
    // after a closing quote, CR in an unquoted field, extreme bytes, a
    // mid-field quote, LF inside quotes and an unterminated quote.
    @(posedge clk);
    queue_text("a,\"b\"\"c\"");
    queue_eol(8'h00);
    queue_text("\"x\"y\rz,");
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_eol(8'hFF);
    queue_text("a\"b,\"\n");
    queue_eol(8'h5A);
    drain();

    // Random lines, one batch per separator setting.
    foreach (sep_plan[p]) begin
      write_separator(sep_plan[p]);
      target = queued_items + 25;
      while (queued_items < target) begin
        if ($urandom_range(0, 5) == 0) queue_noise();
        else queue_random_line();
      end
      drain();
    end

    // Limits: an overlong quoted field, then a few empty fields.
    write_separator(SEPARATOR_RESET);
    queue_byte(QUOTE_BYTE);
    repeat (FIELD_BYTES + 8) queue_byte(any_but_quote());
    queue_byte(QUOTE_BYTE);
    queue_byte(exp_sep);
    repeat (4) queue_byte(exp_sep);
    queue_text("zz");
    queue_eol(8'h00);
    drain();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
